// ===== src/tsre_pkg.sv =====
// Shared types and constants for the transparent span run-length encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tsre_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 4096;
	localparam int unsigned MAX_ROWS_DEF  = 65536;
	localparam int unsigned QUEUE_DEPTH   = 4;
	localparam int unsigned NUM_SLOTS     = 4;

	localparam logic [12:0] ROW_WIDTH_RST   = 13'd64;
	localparam logic [7:0]  TRANSPARENT_RST = 8'd0;

	// Slot positions inside one command, in the order the writes leave.
	localparam int unsigned SLOT_ROW    = 0;
	localparam int unsigned SLOT_DATA   = 1;
	localparam int unsigned SLOT_HEADER = 2;
	localparam int unsigned SLOT_END    = 3;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_ROW    = 2'd2
	} kind_t;

	typedef enum logic [0:0] {
		REG_ROW_WIDTH   = 1'b0,
		REG_TRANSPARENT = 1'b1
	} reg_index_t;

	typedef struct packed {
		kind_t       kind;
		logic [23:0] addr;
		logic [31:0] word;
		logic        ovf;
	} slot_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0]            en;
		slot_t [NUM_SLOTS-1:0]           slot;
	} cmd_t;

endpackage

// ===== src/tsre_front.sv =====
// Front part: takes pixels, keeps the row and span state and turns each pixel
// into one command of up to four memory writes. Depends on tsre_pkg.
module tsre_front #(
	parameter int unsigned MAX_WIDTH = tsre_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_ROWS  = tsre_pkg::MAX_ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  tsre_pkg::reg_index_t cfg_index,
	input  logic [12:0]         cfg_data,
	input  logic                take,
	input  logic [7:0]          pixel,
	input  logic                last_pixel,
	output logic                cmd_push,
	output tsre_pkg::cmd_t      cmd
);
	import tsre_pkg::*;

	localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned LEN_W = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RC_W  = $clog2(MAX_ROWS + 1);
	localparam logic [16:0] MAX_W17 = 17'(MAX_WIDTH);
	localparam logic [RC_W-1:0] ROW_LIMIT = RC_W'(MAX_ROWS);

	logic [12:0]      row_width_q;
	logic [7:0]       transparent_q;
	logic [COL_W-1:0] column_q;
	logic [RC_W-1:0]  row_count_q;
	logic [23:0]      offset_q;
	logic [23:0]      span_off_q;
	logic [COL_W-1:0] span_x_q;
	logic [LEN_W-1:0] span_len_q;
	logic             in_span_q;
	logic [23:0]      pending_q;
	logic [1:0]       pcount_q;
	logic             ovf_q;

	logic [16:0]      w;
	logic             nontrans, start, full_word, row_end, span_live, close, padded, data_en;
	logic [1:0]       pc_eff, pc_new;
	logic [23:0]      pend_eff, pend_new;
	logic [LEN_W-1:0] len_eff, len_new;
	logic [COL_W-1:0] start_x;
	logic [23:0]      start_off, o1, o2;
	logic             c1, c2, ovf_new;
	logic [RC_W-1:0]  rc_new;
	logic [31:0]      data_word;

	always_comb begin
		if (row_width_q == 13'd0) begin
			w = 17'd1;
		end else if (17'(row_width_q) > MAX_W17) begin
			w = MAX_W17;
		end else begin
			w = 17'(row_width_q);
		end

		nontrans = pixel != transparent_q;
		start    = nontrans && !in_span_q;
		pc_eff   = start ? 2'd0 : pcount_q;
		pend_eff = start ? 24'd0 : pending_q;
		len_eff  = start ? '0 : span_len_q;
		start_x  = start ? column_q : span_x_q;
		start_off = start ? offset_q : span_off_q;

		// Opening a span reserves the header slot ahead of its bytes.
		{c1, o1} = start ? ({1'b0, offset_q} + 25'd4) : {1'b0, offset_q};

		full_word = nontrans && (pc_eff == 2'd3);
		pend_new  = pend_eff;
		pc_new    = pc_eff;
		if (full_word) begin
			pend_new = 24'd0;
			pc_new   = 2'd0;
		end else if (nontrans) begin
			case (pc_eff)
				2'd0:    pend_new[7:0]   = pixel;
				2'd1:    pend_new[15:8]  = pixel;
				default: pend_new[23:16] = pixel;
			endcase
			pc_new = pc_eff + 2'd1;
		end
		len_new = nontrans ? (len_eff + LEN_W'(1)) : len_eff;

		row_end   = ((17'(column_q) + 17'd1) >= w) || last_pixel;
		span_live = in_span_q || nontrans;
		close     = span_live && (!nontrans || row_end);
		padded    = close && (pc_new != 2'd0);
		data_en   = full_word || padded;
		data_word = full_word ? {pixel, pend_eff} : {8'd0, pend_new};

		{c2, o2} = data_en ? ({1'b0, o1} + 25'd4) : {1'b0, o1};
		ovf_new  = ovf_q | c1 | c2;
		rc_new   = (row_end && (row_count_q < ROW_LIMIT)) ? (row_count_q + RC_W'(1))
			: row_count_q;

		cmd.en[SLOT_ROW]           = column_q == '0;
		cmd.slot[SLOT_ROW].kind    = KIND_ROW;
		cmd.slot[SLOT_ROW].addr    = 24'(row_count_q);
		cmd.slot[SLOT_ROW].word    = {8'd0, offset_q};
		cmd.slot[SLOT_ROW].ovf     = ovf_q;

		cmd.en[SLOT_DATA]          = data_en;
		cmd.slot[SLOT_DATA].kind   = KIND_DATA;
		cmd.slot[SLOT_DATA].addr   = o1;
		cmd.slot[SLOT_DATA].word   = data_word;
		cmd.slot[SLOT_DATA].ovf    = ovf_new;

		cmd.en[SLOT_HEADER]        = close;
		cmd.slot[SLOT_HEADER].kind = KIND_HEADER;
		cmd.slot[SLOT_HEADER].addr = start_off;
		cmd.slot[SLOT_HEADER].word = {16'(len_new), 16'(start_x)};
		cmd.slot[SLOT_HEADER].ovf  = ovf_new;

		cmd.en[SLOT_END]           = last_pixel;
		cmd.slot[SLOT_END].kind    = KIND_ROW;
		cmd.slot[SLOT_END].addr    = 24'(rc_new);
		cmd.slot[SLOT_END].word    = {8'd0, o2};
		cmd.slot[SLOT_END].ovf     = ovf_new;

		cmd_push = take && (cmd.en != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q   <= ROW_WIDTH_RST;
			transparent_q <= TRANSPARENT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROW_WIDTH:   row_width_q   <= cfg_data;
				REG_TRANSPARENT: transparent_q <= cfg_data[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			row_count_q <= '0;
			offset_q    <= '0;
			span_off_q  <= '0;
			span_x_q    <= '0;
			span_len_q  <= '0;
			in_span_q   <= 1'b0;
			pending_q   <= '0;
			pcount_q    <= '0;
			ovf_q       <= 1'b0;
		end else if (take) begin
			if (last_pixel) begin
				// The sprite is finished; the next pixel starts a fresh one.
				column_q    <= '0;
				row_count_q <= '0;
				offset_q    <= '0;
				span_off_q  <= '0;
				span_x_q    <= '0;
				span_len_q  <= '0;
				in_span_q   <= 1'b0;
				pending_q   <= '0;
				pcount_q    <= '0;
				ovf_q       <= 1'b0;
			end else begin
				column_q    <= row_end ? '0 : (column_q + COL_W'(1));
				row_count_q <= rc_new;
				offset_q    <= o2;
				span_off_q  <= start_off;
				span_x_q    <= start_x;
				span_len_q  <= close ? '0 : len_new;
				in_span_q   <= span_live && !close;
				pending_q   <= close ? 24'd0 : pend_new;
				pcount_q    <= close ? 2'd0 : pc_new;
				ovf_q       <= ovf_new;
			end
		end
	end

endmodule

// ===== src/tsre_queue.sv =====
// Short command queue between the front and back parts.
// Register based, one write and one read port. Depends on tsre_pkg.
module tsre_queue #(
	parameter int unsigned DEPTH = tsre_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  tsre_pkg::cmd_t din,
	input  logic           rd,
	output tsre_pkg::cmd_t dout,
	output logic           full,
	output logic           valid
);
	import tsre_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full  = count_q == FULL_CNT;
	assign valid = count_q != '0;
	assign dout  = entry_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : (wptr_q + PTR_W'(1));
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : (rptr_q + PTR_W'(1));
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/tsre_back.sv =====
// Back part: walks the enabled slots of the head command, one write per cycle while
// the result register is free or popped, into that register. Depends on tsre_pkg.
module tsre_back (
	input  logic           clk,
	input  logic           arst_n,
	input  tsre_pkg::cmd_t head,
	input  logic           head_valid,
	output logic           head_pop,
	input  logic           pop,
	output logic           empty,
	output logic [1:0]     kind,
	output logic [23:0]    address,
	output logic [31:0]    word,
	output logic           overflow,
	output logic           last
);
	import tsre_pkg::*;

	logic [NUM_SLOTS-1:0] done_q, remaining, sel, rest;
	logic                 out_valid_q, load;
	slot_t                pick;
	kind_t                kind_q;
	logic [23:0]          address_q;
	logic [31:0]          word_q;
	logic                 overflow_q, last_q;

	always_comb begin
		remaining = head.en & ~done_q;
		sel  = '0;
		pick = head.slot[0];
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (remaining[i]) begin
				sel  = '0;
				sel[i] = 1'b1;
				pick = head.slot[i];
			end
		end
		rest     = remaining & ~sel;
		load     = head_valid && (!out_valid_q || pop);
		head_pop = load && (rest == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (head_pop) begin
				done_q <= '0;
			end else if (load) begin
				done_q <= done_q | sel;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q     <= pick.kind;
			address_q  <= pick.addr;
			word_q     <= pick.word;
			overflow_q <= pick.ovf;
			last_q     <= rest == '0;
		end
	end

	assign empty    = !out_valid_q;
	assign kind     = kind_q;
	assign address  = address_q;
	assign word     = word_q;
	assign overflow = overflow_q;
	assign last     = last_q;

endmodule

// ===== src/transparent_span_rle_encoder_top.sv =====
// Top level of the transparent span run-length sprite encoder.
// Instantiates tsre_front, tsre_queue and tsre_back; depends on tsre_pkg.
//
//   channel   direction  handshake               payload
//   pixels    in         push / full             pixel, last_pixel
//   writes    out        empty / pop             kind, address, word, overflow, last
//   config    in         cfg_write               cfg_index, cfg_data
//
// One pixel is accepted per cycle while the command queue has room; a pixel's
// writes (zero to four) then leave one per cycle while pop is held, so the write
// port sets the sustained rate when pixels cause more than one write on average.
// Each command is registered in the queue and each write in the result register.
// Reset clears all control state at once; there is no clearing pass.
// Stalls on pop fill the queue, and full then holds off further pixels.
module transparent_span_rle_encoder_top #(
	parameter int unsigned MAX_WIDTH = tsre_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_ROWS  = tsre_pkg::MAX_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           pixel,
	input  logic                 last_pixel,
	output logic                 empty,
	input  logic                 pop,
	output logic [1:0]           kind,
	output logic [23:0]          address,
	output logic [31:0]          word,
	output logic                 overflow,
	output logic                 last,
	input  logic                 cfg_write,
	input  tsre_pkg::reg_index_t cfg_index,
	input  logic [12:0]          cfg_data
);
	import tsre_pkg::*;

	logic take, cmd_push, head_valid, head_pop;
	cmd_t cmd, head;

	assign take = push && !full;

	tsre_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_ROWS  (MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.take       (take),
		.pixel      (pixel),
		.last_pixel (last_pixel),
		.cmd_push   (cmd_push),
		.cmd        (cmd)
	);

	tsre_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.din    (cmd),
		.rd     (head_pop),
		.dout   (head),
		.full   (full),
		.valid  (head_valid)
	);

	tsre_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.kind       (kind),
		.address    (address),
		.word       (word),
		.overflow   (overflow),
		.last       (last)
	);

endmodule

// ===== src/tsre_checker.sv =====
// Port-level checks for the transparent span run-length encoder, bound to the
// top level. Depends on transparent_span_rle_encoder_top and tsre_pkg.
module tsre_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  kind,
	input logic [23:0] address,
	input logic [31:0] word
);
	import tsre_pkg::*;

	// A reset that has been held over a clock edge leaves the result side empty.
	a_reset_empty: assert property (@(posedge clk) (!arst_n && $past(!arst_n)) |-> empty)
		else $error("result waiting during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(address) && $stable(word)))
		else $error("stalled request changed");

	// Spans and their bytes always sit on whole words.
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == KIND_DATA || kind == KIND_HEADER)) |-> (address[1:0] == 2'b00))
		else $error("unaligned memory write");

	a_table_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_ROW) |-> (word[1:0] == 2'b00))
		else $error("row table offset not word aligned");

	a_header_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_HEADER) |-> (word[31:16] != 16'd0))
		else $error("span header with zero length");

endmodule

bind transparent_span_rle_encoder_top tsre_checker u_tsre_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.empty   (empty),
	.pop     (pop),
	.kind    (kind),
	.address (address),
	.word    (word)
);
